### src/heightmap_vertex_normal_core_macros.svh
// assertion macros for the heightmap vertex normal core
// used by files that check their own sequencing; expects clk and rst_n in scope
`ifndef HEIGHTMAP_VERTEX_NORMAL_CORE_MACROS_SVH
`define HEIGHTMAP_VERTEX_NORMAL_CORE_MACROS_SVH

// same-cycle implication
`define HVN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hvn same-cycle check failed");

// next-cycle implication
`define HVN_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hvn next-cycle check failed");

`endif

### src/hvn_pkg.sv
// shared types, constants and small tables of the heightmap vertex normal core
// no dependencies
`timescale 1ns / 1ps
package hvn_pkg;

  localparam int HEIGHT_W      = 16;
  localparam int STORE_DEPTH   = 65536;
  localparam int STORE_AW      = 16;
  localparam int GRID_SIZE_DEF = 256;
  localparam int CFG_W         = 20;
  localparam logic [CFG_W-1:0] CFG_RESET = 20'd45875;

  localparam int VEC_W      = 28;
  localparam int SSUM_W     = 56;
  localparam int ROOT_W     = 32;
  localparam int OPND_W     = 64;
  localparam int NUM_W      = 56;
  localparam int DIV_STEPS  = 26;
  localparam int SQRT_STEPS = 32;
  localparam int REM_W      = 34;

  localparam logic [2:0] FACE_FINAL = 3'd6;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                func;
    logic [7:0]          column;
    logic [7:0]          row;
    logic [HEIGHT_W-1:0] height_sample;
  } in_t;

  typedef struct packed {
    logic               is_normal;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FACE,
    ST_SQ,
    ST_ROOT,
    ST_ROOT_WAIT,
    ST_DIV,
    ST_DIV_WAIT,
    ST_DIV_POST,
    ST_DONE
  } state_t;

  typedef enum logic {
    UOP_SQRT,
    UOP_DIV
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // neighborhood position to row / column offset (0..2 maps to -1..+1)
  function automatic logic [1:0] pos_row(input logic [3:0] p);
    logic [1:0] r;
    case (p)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      4'd6, 4'd7, 4'd8: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pos_col(input logic [3:0] p);
    logic [1:0] c;
    case (p)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      4'd2, 4'd5, 4'd8: c = 2'd2;
      default:          c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

### src/hvn_ram.sv
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module hvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/hvn_unit.sv
// shared bit-serial square root and divider unit
// depends on hvn_pkg; the divider uses the last root as its divisor
`timescale 1ns / 1ps
module hvn_unit import hvn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  unit_req_t            req,
  input  logic [OPND_W-1:0]    opnd,
  output unit_sts_t            sts,
  output logic [ROOT_W-1:0]    root,
  output logic [DIV_STEPS-1:0] quo
);

  logic             busy_r;
  unit_op_t         op_r;
  logic [4:0]       cnt_r;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_nxt;
  logic [OPND_W-1:0] work_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W-1:0] sub_a;
  logic [REM_W-1:0] sub_b;
  logic [REM_W:0]   diff;
  logic             ge;
  logic [4:0]       last;

  assign last     = (op_r == UOP_SQRT) ? 5'(SQRT_STEPS - 1) : 5'(DIV_STEPS - 1);
  assign sts.busy = busy_r;
  assign sts.done = busy_r && (cnt_r == last);
  assign root     = root_r;
  assign quo      = work_r[DIV_STEPS-1:0];

  always_comb begin
    if (op_r == UOP_SQRT) begin
      sub_a = {rem_r[ROOT_W-1:0], work_r[OPND_W-1 -: 2]};
      sub_b = {root_r, 2'b01};
    end else begin
      sub_a = {1'b0, rem_r[ROOT_W-1:0], work_r[OPND_W-1]};
      sub_b = {2'b00, root_r};
    end
    diff    = {1'b0, sub_a} - {1'b0, sub_b};
    ge      = !diff[REM_W];
    rem_nxt = ge ? diff[REM_W-1:0] : sub_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (sts.done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      cnt_r <= '0;
      if (req.op == UOP_SQRT) begin
        rem_r  <= '0;
        root_r <= '0;
        work_r <= opnd;
      end else begin
        rem_r  <= {{(REM_W - (NUM_W - DIV_STEPS)){1'b0}}, opnd[NUM_W-1:DIV_STEPS]};
        work_r <= {opnd[DIV_STEPS-1:0], {(OPND_W - DIV_STEPS){1'b0}}};
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      rem_r <= rem_nxt;
      if (op_r == UOP_SQRT) begin
        work_r <= {work_r[OPND_W-3:0], 2'b00};
        root_r <= {root_r[ROOT_W-2:0], ge};
      end else begin
        work_r <= {work_r[OPND_W-2:0], ge};
      end
    end
  end

endmodule

### src/heightmap_vertex_normal_core.sv
// Heightmap vertex normal core: stores a 256 x 256 grid of 16-bit heights and returns the
// Q1.15 unit normal of a grid vertex. A write transaction or a query outside the grid goes
// straight to the done state; its result is then registered into the output register once
// that is free. A query inside the grid reads 9 heights, then runs each touching face (up to
// six) and the final sum through one shared bit-serial square root / divider: per face
// 32 root steps and three 26-step divides with setup and post-processing, and the same for
// the final normalization. A face missing at the border is skipped, and a zero face vector
// skips the unit. The shared unit retires one result bit per cycle. The next transaction is
// taken while a finished result waits at the output.
`timescale 1ns / 1ps
`include "heightmap_vertex_normal_core_macros.svh"
module heightmap_vertex_normal_core import hvn_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  state_t state_r, state_nxt;
  logic [CFG_W-1:0] ratio_r;
  logic [7:0] col_r, row_r;
  logic [3:0] cnt_r;
  logic rd_ok_r;
  logic [HEIGHT_W-1:0] h_r [9];
  logic [2:0] face_r;
  logic [1:0] comp_r;
  logic signed [VEC_W-1:0] vec_r [3];
  logic signed [VEC_W-1:0] acc_r [3];
  logic [SSUM_W-1:0] prod_r, ssum_r;
  logic res_is_r;
  logic signed [15:0] res_r [3];
  logic out_valid_r;
  out_t out_r;

  logic in_accept, in_range, out_free, final_w, ssum_zero;
  logic ram_we;
  logic [STORE_AW-1:0] ram_addr, rd_addr;
  logic [HEIGHT_W-1:0] ram_rdata;
  logic [9:0] grow, gcol;
  logic rd_ok;
  unit_req_t unit_req;
  unit_sts_t unit_sts;
  logic [OPND_W-1:0] unit_opnd;
  logic [ROOT_W-1:0] unit_root;
  logic [DIV_STEPS-1:0] unit_quo;

  logic vx0, vxm, vy0, vym, fvalid, second;
  logic [HEIGHT_W-1:0] ha, hb, hc, hd;
  logic signed [16:0] dx, dz;
  logic signed [VEC_W-1:0] fvec [3];
  logic [1:0] sel_idx;
  logic signed [VEC_W-1:0] vec_sel;
  logic signed [SSUM_W-1:0] prod_full;
  logic [VEC_W-1:0] mag;
  logic [NUM_W-1:0] num;
  logic [24:0] fmag;
  logic signed [VEC_W-1:0] fdelta;
  logic [16:0] qneg;
  logic signed [15:0] qsat;

  assign in_accept = in_valid && !in_stall;
  assign in_range  = (32'(in_data.column) < GRID_SIZE) && (32'(in_data.row) < GRID_SIZE);
  assign out_free  = !out_valid_r || !out_stall;
  assign final_w   = (face_r == FACE_FINAL);
  assign ssum_zero = (ssum_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // quad validity around the vertex
  assign vx0 = (32'(col_r) + 32'd1) < GRID_SIZE;
  assign vy0 = (32'(row_r) + 32'd1) < GRID_SIZE;
  assign vxm = (col_r != 8'd0);
  assign vym = (row_r != 8'd0);

  // neighborhood read address
  assign grow    = {2'b00, row_r} + {8'd0, pos_row(cnt_r)} - 10'd1;
  assign gcol    = {2'b00, col_r} + {8'd0, pos_col(cnt_r)} - 10'd1;
  assign rd_ok   = (grow[9:8] == 2'b00) && (gcol[9:8] == 2'b00);
  assign rd_addr = {grow[7:0], gcol[7:0]};

  // face corners and vector
  always_comb begin
    case (face_r)
      3'd0: begin
        ha = h_r[4]; hb = h_r[7]; hc = h_r[8]; hd = h_r[5]; second = 1'b0; fvalid = vx0 && vy0;
      end
      3'd1: begin
        ha = h_r[4]; hb = h_r[7]; hc = h_r[8]; hd = h_r[5]; second = 1'b1; fvalid = vx0 && vy0;
      end
      3'd2: begin
        ha = h_r[3]; hb = h_r[6]; hc = h_r[7]; hd = h_r[4]; second = 1'b1; fvalid = vxm && vy0;
      end
      3'd3: begin
        ha = h_r[1]; hb = h_r[4]; hc = h_r[5]; hd = h_r[2]; second = 1'b0; fvalid = vx0 && vym;
      end
      3'd4: begin
        ha = h_r[0]; hb = h_r[3]; hc = h_r[4]; hd = h_r[1]; second = 1'b0; fvalid = vxm && vym;
      end
      3'd5: begin
        ha = h_r[0]; hb = h_r[3]; hc = h_r[4]; hd = h_r[1]; second = 1'b1; fvalid = vxm && vym;
      end
      default: begin
        ha = h_r[4]; hb = h_r[4]; hc = h_r[4]; hd = h_r[4]; second = 1'b0; fvalid = 1'b0;
      end
    endcase
    if (second) begin
      dx = $signed({1'b0, ha}) - $signed({1'b0, hd});
      dz = $signed({1'b0, hd}) - $signed({1'b0, hc});
    end else begin
      dx = $signed({1'b0, hb}) - $signed({1'b0, hc});
      dz = $signed({1'b0, ha}) - $signed({1'b0, hb});
    end
    fvec[0] = {{5{dx[16]}}, dx, 6'b0};
    fvec[1] = $signed({{(VEC_W - CFG_W){1'b0}}, ratio_r});
    fvec[2] = {{5{dz[16]}}, dz, 6'b0};
  end

  // component select, square and divider operands
  always_comb begin
    sel_idx = (state_r == ST_SQ) ? cnt_r[1:0] : comp_r;
    case (sel_idx)
      2'd0:    vec_sel = vec_r[0];
      2'd1:    vec_sel = vec_r[1];
      2'd2:    vec_sel = vec_r[2];
      default: vec_sel = vec_r[2];
    endcase
    prod_full = vec_sel * vec_sel;
    mag = vec_sel[VEC_W-1] ? VEC_W'(-vec_sel) : VEC_W'(vec_sel);
    if (final_w) begin
      num = {9'd0, mag, 19'd0} + {25'd0, unit_root[ROOT_W-1:1]};
    end else begin
      num = {mag[23:0], 32'd0} + {25'd0, unit_root[ROOT_W-1:1]};
    end
    if (state_r == ST_DIV) begin
      unit_opnd = {{(OPND_W - NUM_W){1'b0}}, num};
    end else if (final_w) begin
      unit_opnd = {ssum_r, 8'd0};
    end else begin
      unit_opnd = {ssum_r[SSUM_W-9:0], 16'd0};
    end
  end

  // quotient post-processing
  always_comb begin
    fmag   = (unit_quo > 26'h1000000) ? 25'h1000000 : unit_quo[24:0];
    fdelta = vec_sel[VEC_W-1] ? -$signed({3'b000, fmag}) : $signed({3'b000, fmag});
    qneg   = 17'd0 - {1'b0, unit_quo[15:0]};
    if (vec_sel[VEC_W-1]) begin
      qsat = (unit_quo > 26'd32768) ? -16'sd32768 : $signed(qneg[15:0]);
    end else begin
      qsat = (unit_quo > 26'd32767) ? 16'sd32767 : $signed(unit_quo[15:0]);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.func == FUNC_QUERY && in_range) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_READ: begin
        if (cnt_r == 4'd9) state_nxt = ST_FACE;
      end
      ST_FACE: begin
        if (final_w || fvalid) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        if (cnt_r == 4'd3) state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (!ssum_zero) begin
          state_nxt = ST_ROOT_WAIT;
        end else if (final_w) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_FACE;
        end
      end
      ST_ROOT_WAIT: begin
        if (unit_sts.done) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (unit_sts.done) state_nxt = ST_DIV_POST;
      end
      ST_DIV_POST: begin
        if (comp_r != 2'd2) begin
          state_nxt = ST_DIV;
        end else if (final_w) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_FACE;
        end
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall     = 1'b1;
    ram_we       = 1'b0;
    ram_addr     = rd_addr;
    unit_req     = '{start: 1'b0, op: UOP_SQRT};
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        ram_addr = {in_data.row, in_data.column};
        ram_we   = in_valid && (in_data.func == FUNC_WRITE) && in_range;
      end
      ST_ROOT: begin
        unit_req = '{start: !ssum_zero, op: UOP_SQRT};
      end
      ST_DIV: begin
        unit_req = '{start: 1'b1, op: UOP_DIV};
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ratio_r     <= CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        ratio_r <= cfg_wr_data;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_r.is_normal <= res_is_r;
      out_r.normal_x  <= res_r[0];
      out_r.normal_y  <= res_r[1];
      out_r.normal_z  <= res_r[2];
    end
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          col_r    <= in_data.column;
          row_r    <= in_data.row;
          res_is_r <= in_data.func;
          res_r[0] <= '0;
          res_r[1] <= (in_data.func == FUNC_QUERY) ? 16'sd32767 : 16'sd0;
          res_r[2] <= '0;
          cnt_r    <= '0;
          face_r   <= '0;
          acc_r[0] <= '0;
          acc_r[1] <= '0;
          acc_r[2] <= '0;
        end
      end
      ST_READ: begin
        cnt_r   <= cnt_r + 4'd1;
        rd_ok_r <= rd_ok;
        if (cnt_r != 4'd0) begin
          h_r[cnt_r - 4'd1] <= rd_ok_r ? ram_rdata : '0;
        end
      end
      ST_FACE: begin
        cnt_r  <= '0;
        ssum_r <= '0;
        if (final_w) begin
          vec_r[0] <= acc_r[0];
          vec_r[1] <= acc_r[1];
          vec_r[2] <= acc_r[2];
        end else if (fvalid) begin
          vec_r[0] <= fvec[0];
          vec_r[1] <= fvec[1];
          vec_r[2] <= fvec[2];
        end else begin
          face_r <= face_r + 3'd1;
        end
      end
      ST_SQ: begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r != 4'd3) begin
          prod_r <= prod_full;
        end
        if (cnt_r != 4'd0) begin
          ssum_r <= ssum_r + prod_r;
        end
      end
      ST_ROOT: begin
        comp_r <= '0;
        if (ssum_zero && !final_w) begin
          face_r <= face_r + 3'd1;
        end
      end
      ST_DIV_POST: begin
        comp_r <= comp_r + 2'd1;
        if (final_w) begin
          res_r[comp_r] <= qsat;
        end else begin
          acc_r[comp_r] <= acc_r[comp_r] + fdelta;
          if (comp_r == 2'd2) begin
            face_r <= face_r + 3'd1;
          end
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  hvn_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_data.height_sample),
    .rdata (ram_rdata)
  );

  hvn_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (unit_req),
    .opnd  (unit_opnd),
    .sts   (unit_sts),
    .root  (unit_root),
    .quo   (unit_quo)
  );

  `HVN_ASSERT_IMP(a_start_free, unit_req.start, !unit_sts.busy)
  `HVN_ASSERT_IMP(a_wait_busy, state_r == ST_DIV_WAIT || state_r == ST_ROOT_WAIT, unit_sts.busy)
  `HVN_ASSERT_IMP(a_face_bound, state_r != ST_IDLE && state_r != ST_DONE, face_r <= FACE_FINAL)
  `HVN_ASSERT_NXT(a_write_ack, in_accept && in_data.func == FUNC_WRITE, state_r == ST_DONE)

endmodule

### tb/sv/tb_heightmap_vertex_normal_core.sv
// testbench for heightmap_vertex_normal_core: height writes and vertex normal queries
// checked against an in-bench fixed-point normal predictor; depends on hvn_pkg and the core
`timescale 1ns / 1ps
module tb_heightmap_vertex_normal_core;
  import hvn_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  heightmap_vertex_normal_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  localparam int WATCHDOG_LIMIT = 20000;

  in_t          pending_items[$];
  out_t         expected_normals[$];
  logic [15:0]  grid_heights[65536];
  bit           grid_written[65536];
  logic [19:0]  ratio_now;
  longint       normal_sum[3];
  int           mismatches;
  int           accepted_items = 0;
  int           idle_cycles = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;
  bit           in_fire = 1'b0;
  longint unsigned cycle_no = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint div_round(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint height_of(int c, int r);
    return longint'(grid_heights[r * 256 + c]);
  endfunction

  function automatic void add_face_normal(longint dx, longint dz);
    longint v[3];
    longint unsigned s;
    longint r, u;
    v[0] = dx * 64;
    v[1] = longint'(ratio_now);
    v[2] = dz * 64;
    s = longint'(v[0] * v[0]) + longint'(v[1] * v[1]) + longint'(v[2] * v[2]);
    if (s == 0) return;
    r = longint'(int_sqrt(s << 16));
    for (int i = 0; i < 3; i++) begin
      u = div_round(v[i] * (longint'(1) << 32), r);
      if (u > (longint'(1) << 24)) u = longint'(1) << 24;
      if (u < -(longint'(1) << 24)) u = -(longint'(1) << 24);
      normal_sum[i] += u;
    end
  endfunction

  function automatic void add_quad_faces(int qx, int qy, bit upper, bit lower);
    longint a, b, c, d;
    if (qx < 0 || qy < 0 || qx + 1 >= 256 || qy + 1 >= 256) return;
    a = height_of(qx, qy);
    b = height_of(qx, qy + 1);
    c = height_of(qx + 1, qy + 1);
    d = height_of(qx + 1, qy);
    if (upper) add_face_normal(b - c, a - b);
    if (lower) add_face_normal(a - d, d - c);
  endfunction

  function automatic logic signed [15:0] to_q15(longint s, longint q);
    longint n;
    n = div_round(s * (longint'(1) << 19), q);
    if (n > 32767) n = 32767;
    if (n < -32768) n = -32768;
    return n[15:0];
  endfunction

  function automatic out_t vertex_normal(int c, int r);
    out_t o;
    longint unsigned t;
    longint q;
    o.is_normal = 1'b1;
    o.normal_x = 16'sd0;
    o.normal_y = 16'sd32767;
    o.normal_z = 16'sd0;
    normal_sum[0] = 0;
    normal_sum[1] = 0;
    normal_sum[2] = 0;
    add_quad_faces(c, r, 1, 1);
    add_quad_faces(c - 1, r, 0, 1);
    add_quad_faces(c, r - 1, 1, 0);
    add_quad_faces(c - 1, r - 1, 1, 1);
    t = longint'(normal_sum[0] * normal_sum[0]) + longint'(normal_sum[1] * normal_sum[1])
      + longint'(normal_sum[2] * normal_sum[2]);
    if (t == 0) return o;
    q = longint'(int_sqrt(t << 8));
    o.normal_x = to_q15(normal_sum[0], q);
    o.normal_y = to_q15(normal_sum[1], q);
    o.normal_z = to_q15(normal_sum[2], q);
    return o;
  endfunction

  task automatic put_write(int c, int r, logic [15:0] h);
    in_t  it;
    out_t o;
    it.func = FUNC_WRITE;
    it.column = c[7:0];
    it.row = r[7:0];
    it.height_sample = h;
    grid_heights[r * 256 + c] = h;
    grid_written[r * 256 + c] = 1'b1;
    o = '0;
    pending_items.insert(pending_items.size(), it);
    expected_normals.insert(expected_normals.size(), o);
  endtask

  function automatic logic [15:0] rand_height();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'(32'h8000 + $urandom_range(0, 40) - 32'd20);
      default: return 16'($urandom);
    endcase
  endfunction

  // writes any unwritten neighbor first so the query never reads undefined heights
  task automatic put_query(int c, int r);
    in_t it;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if (c + dc >= 0 && c + dc < 256 && r + dr >= 0 && r + dr < 256
            && !grid_written[(r + dr) * 256 + c + dc])
          put_write(c + dc, r + dr, rand_height());
    it.func = FUNC_QUERY;
    it.column = c[7:0];
    it.row = r[7:0];
    it.height_sample = 16'($urandom);
    pending_items.insert(pending_items.size(), it);
    expected_normals.insert(expected_normals.size(), vertex_normal(c, r));
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 5);
      1: return 125 + $urandom_range(0, 5);
      default: return 250 + $urandom_range(0, 5);
    endcase
  endfunction

  task automatic drain_and_set_ratio(logic [19:0] value);
    wait (pending_items.size() == 0 && expected_normals.size() == 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    ratio_now = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: put_write($urandom_range(0, 255), $urandom_range(0, 255), 16'($urandom));
        1, 2, 3, 4, 5: put_query(rand_coord(), rand_coord());
        default: put_write(rand_coord(), rand_coord(), rand_height());
      endcase
    end
  endtask

  initial begin
    logic [19:0] ratios[5];
    rst_n = 1'b0;
    mismatches = 0;
    ratio_now = CFG_RESET;
    foreach (grid_written[i]) grid_written[i] = 1'b0;
    foreach (grid_heights[i]) grid_heights[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // corner, interior and far corner with extreme heights, at the reset ratio
    put_write(0, 0, 16'h0000);
    put_write(1, 0, 16'hffff);
    put_write(0, 1, 16'hffff);
    put_write(1, 1, 16'h0000);
    put_query(0, 0);
    put_query(1, 0);
    put_query(0, 1);
    put_write(128, 128, 16'hffff);
    put_query(128, 128);
    put_query(255, 255);
    put_query(255, 0);
    put_query(0, 255);
    random_items(300);

    ratios[0] = 20'd1;
    ratios[1] = 20'hfffff;
    ratios[2] = 20'd0;
    ratios[3] = 20'($urandom_range(1, 1048575));
    ratios[4] = 20'($urandom_range(100, 100000));
    for (int p = 0; p < 5; p++) begin
      drain_and_set_ratio(ratios[p]);
      if (ratios[p] == 0) begin
        // flat corner with no vertical term gives a zero sum
        put_write(0, 0, 16'h1234);
        put_write(1, 0, 16'h1234);
        put_write(0, 1, 16'h1234);
        put_write(1, 1, 16'h1234);
        put_query(0, 0);
      end
      random_items(340);
    end

    wait (pending_items.size() == 0 && expected_normals.size() == 0);
    repeat (1000) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // sender: sample the handshake at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    cycle_no <= rst_n ? cycle_no + 1 : 0;
  end

  function automatic bit quiet_stretch();
    return cycle_no >= 60000 && cycle_no < 140000;
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) accepted_items <= accepted_items + 1;
      if (in_valid && !in_fire) begin
        in_valid <= 1'b1;
      end else if (pending_items.size() > 0 && (quiet_stretch() || $urandom_range(0, 99) >= 9))
      begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls, with one long hold-off early on
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && accepted_items >= 150) begin
        hold_done <= 1'b1;
        hold_left <= 3000;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet_stretch() && $urandom_range(0, 99) < 9;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t exp_o;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_normals.size() == 0) begin
        $error("unexpected transaction %p", out_data);
        mismatches++;
      end else begin
        exp_o = expected_normals.pop_front();
        if (out_data.is_normal !== exp_o.is_normal) begin
          $error("is_normal expected %0d actual %0d", exp_o.is_normal, out_data.is_normal);
          mismatches++;
        end
        if (out_data.normal_x !== exp_o.normal_x) begin
          $error("normal_x expected %0d actual %0d", exp_o.normal_x, out_data.normal_x);
          mismatches++;
        end
        if (out_data.normal_y !== exp_o.normal_y) begin
          $error("normal_y expected %0d actual %0d", exp_o.normal_y, out_data.normal_y);
          mismatches++;
        end
        if (out_data.normal_z !== exp_o.normal_z) begin
          $error("normal_z expected %0d actual %0d", exp_o.normal_z, out_data.normal_z);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any input or output handshake or config write
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule

### sim.f
+incdir+src
src/hvn_pkg.sv
src/hvn_ram.sv
src/hvn_unit.sv
src/heightmap_vertex_normal_core.sv
tb/sv/tb_heightmap_vertex_normal_core.sv
